>>> hdl/ntc_beta_temperature_convert_unit_macros.svh
// Assertion macros for the NTC beta temperature converter.
// Included by the files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef NTC_BETA_TEMPERATURE_CONVERT_UNIT_MACROS_SVH
`define NTC_BETA_TEMPERATURE_CONVERT_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define NTCB_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define NTCB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/ntcb_pkg.sv
// Shared types and constants for the NTC beta temperature converter.
// No dependencies; imported by every module of the block.
package ntcb_pkg;

  localparam int ADC_BITS_DEF  = 10;
  localparam int LOG_FRAC_DEF  = 16;
  localparam int MANT_W        = 31;  // Q30 mantissa in [1,2)
  localparam int K_W           = 4;   // integer part of log2, 0..11
  localparam int MV_W          = 12;
  localparam int MV_MAX        = 4095;
  localparam int QB            = 18;  // quotient bits kept by the divider
  localparam int TEMP_W        = 18;
  localparam int ZERO_C_CENTIK = 27315;
  localparam int TEMP_MIN      = -30000;
  localparam int TEMP_MAX      = 100000;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic [11:0] GAIN_RST = 12'd1501;
  localparam logic [11:0] REF_RST  = 12'd1500;
  localparam logic [13:0] BETA_RST = 14'd3380;
  localparam logic [15:0] NOM_RST  = 16'd29815;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_HIGH = 2'd2
  } ntcb_status_t;

  typedef enum logic [1:0] {
    REG_ADC_GAIN  = 2'd0,
    REG_REFERENCE = 2'd1,
    REG_BETA      = 2'd2,
    REG_NOMINAL   = 2'd3
  } ntcb_reg_t;

  // Side information that rides along with each sample
  typedef struct packed {
    logic [MV_W-1:0] mv;
    ntcb_status_t    status;
    logic            sat;
  } ntcb_tag_t;

endpackage

>>> hdl/ntcb_log_cell.sv
// One squaring step of the two parallel log2 chains.
// Depends on ntcb_pkg; instantiated once per fraction bit by the top level.
module ntcb_log_cell import ntcb_pkg::*; #(
  parameter int FRAC_BITS = LOG_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_in,
  input  ntcb_tag_t            tag_in,
  input  logic [MANT_W-1:0]    ma_in,
  input  logic [MANT_W-1:0]    mb_in,
  input  logic [FRAC_BITS-1:0] fa_in,
  input  logic [FRAC_BITS-1:0] fb_in,
  input  logic [K_W-1:0]       ka_in,
  input  logic [K_W-1:0]       kb_in,
  output logic                 v_out,
  output ntcb_tag_t            tag_out,
  output logic [MANT_W-1:0]    ma_out,
  output logic [MANT_W-1:0]    mb_out,
  output logic [FRAC_BITS-1:0] fa_out,
  output logic [FRAC_BITS-1:0] fb_out,
  output logic [K_W-1:0]       ka_out,
  output logic [K_W-1:0]       kb_out
);

  logic                   v_r;
  ntcb_tag_t              tag_r;
  logic [MANT_W-1:0]      ma_r, mb_r, ma_nxt, mb_nxt;
  logic [FRAC_BITS-1:0]   fa_r, fb_r, fa_nxt, fb_nxt;
  logic [K_W-1:0]         ka_r, kb_r;
  logic [2*MANT_W-1:0]    sqa, sqb;
  logic [MANT_W:0]        ta, tb;

  // Square both mantissas, keep Q30, halve when the square reaches two
  always_comb begin
    sqa    = {{MANT_W{1'b0}}, ma_in} * {{MANT_W{1'b0}}, ma_in};
    sqb    = {{MANT_W{1'b0}}, mb_in} * {{MANT_W{1'b0}}, mb_in};
    ta     = sqa[2*MANT_W-1:MANT_W-1];
    tb     = sqb[2*MANT_W-1:MANT_W-1];
    ma_nxt = ta[MANT_W] ? ta[MANT_W:1] : ta[MANT_W-1:0];
    mb_nxt = tb[MANT_W] ? tb[MANT_W:1] : tb[MANT_W-1:0];
    fa_nxt = {fa_in[FRAC_BITS-2:0], ta[MANT_W]};
    fb_nxt = {fb_in[FRAC_BITS-2:0], tb[MANT_W]};
  end

  // Hand the step to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
    if (en) begin
      tag_r <= tag_in;
      ma_r  <= ma_nxt;
      mb_r  <= mb_nxt;
      fa_r  <= fa_nxt;
      fb_r  <= fb_nxt;
      ka_r  <= ka_in;
      kb_r  <= kb_in;
    end
  end

  assign v_out   = v_r;
  assign tag_out = tag_r;
  assign ma_out  = ma_r;
  assign mb_out  = mb_r;
  assign fa_out  = fa_r;
  assign fb_out  = fb_r;
  assign ka_out  = ka_r;
  assign kb_out  = kb_r;

endmodule

>>> hdl/ntcb_div_cell.sv
// One restoring-division step: a single quotient bit per cell.
// Depends on ntcb_pkg; instantiated QB times by the top level.
module ntcb_div_cell import ntcb_pkg::*; #(
  parameter int REM_W = 57,
  parameter int DEN_W = 39,
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             v_in,
  input  ntcb_tag_t        tag_in,
  input  logic [REM_W-1:0] rem_in,
  input  logic [DEN_W-1:0] den_in,
  input  logic [QB-1:0]    q_in,
  output logic             v_out,
  output ntcb_tag_t        tag_out,
  output logic [REM_W-1:0] rem_out,
  output logic [DEN_W-1:0] den_out,
  output logic [QB-1:0]    q_out
);

  logic             v_r;
  ntcb_tag_t        tag_r;
  logic [REM_W-1:0] rem_r, rem_nxt, trial;
  logic [DEN_W-1:0] den_r;
  logic [QB-1:0]    q_r, q_nxt;
  logic             ge;

  // Compare against the shifted divisor, subtract on a hit
  always_comb begin
    trial   = REM_W'(den_in) << SHIFT;
    ge      = (rem_in >= trial);
    rem_nxt = ge ? (rem_in - trial) : rem_in;
    q_nxt   = {q_in[QB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
    if (en) begin
      tag_r <= tag_in;
      rem_r <= rem_nxt;
      den_r <= den_in;
      q_r   <= q_nxt;
    end
  end

  assign v_out   = v_r;
  assign tag_out = tag_r;
  assign rem_out = rem_r;
  assign den_out = den_r;
  assign q_out   = q_r;

endmodule

>>> hdl/ntc_beta_temperature_convert_unit.sv
// Top level of the NTC beta temperature converter: front end, log and divider chains.
// Depends on ntcb_pkg, ntcb_log_cell, ntcb_div_cell and the macros header.
//
//  channel  | dir | beat content
//  ---------+-----+------------------------------------------------------------
//  in_      | in  | tdata: raw_sample
//  out_     | out | tdata: millivolts, temp_centi_c, status
//  cfg_     | in  | write enable, register index, write data
//
// One sample is accepted per cycle unless the result register is stalled.
// The pipeline runs through the log2 chain (one squaring cell per fraction bit)
// and the divider chain (one cell per quotient bit, 18 cells).
// The whole pipeline holds while a result waits on out_tready.
// Synchronous active-low reset clears valid bits and loads register defaults.
`include "ntc_beta_temperature_convert_unit_macros.svh"
module ntc_beta_temperature_convert_unit import ntcb_pkg::*; #(
  parameter int ADC_BITS      = ADC_BITS_DEF,
  parameter int LOG_FRAC_BITS = LOG_FRAC_DEF,
  localparam int IN_W         = ((ADC_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,   // [ADC_BITS-1:0] raw_sample, rest zero
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,  // [11:0] millivolts, [29:12] temp_centi_c,
                                      // [31:30] status
  input  logic            cfg_we,
  input  logic [1:0]      cfg_addr,
  input  logic [15:0]     cfg_wdata
);

  localparam int F     = LOG_FRAC_BITS;
  localparam int LW    = K_W + F;
  localparam int GP    = 12 + ADC_BITS;
  localparam int TLW   = LW + 19;
  localparam int DW    = F + 24;
  localparam int UDW   = F + 23;
  localparam int NUMW  = 37 + F;
  localparam int NW    = F + 38;
  localparam int REM_W = F + 41;

  // Configuration registers
  logic [11:0] gain_r, ref_r;
  logic [13:0] beta_r;
  logic [15:0] nom_r;
  logic [20:0] b100_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      ref_r  <= REF_RST;
      beta_r <= BETA_RST;
      nom_r  <= NOM_RST;
    end else if (cfg_we) begin
      unique case (ntcb_reg_t'(cfg_addr))
        REG_ADC_GAIN:  gain_r <= cfg_wdata[11:0];
        REG_REFERENCE: ref_r  <= cfg_wdata[11:0];
        REG_BETA:      beta_r <= cfg_wdata[13:0];
        REG_NOMINAL:   nom_r  <= cfg_wdata[15:0];
        default:       gain_r <= gain_r;
      endcase
    end
  end

  // Beta times 100, settles long before a sample reaches its use
  always_ff @(posedge clk) begin
    b100_r <= 21'(beta_r) * 21'(100);
  end

  logic adv;
  logic out_v_r;
  logic [31:0] out_data_r;

  // Advance every stage unless the result register is stalled
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  // Stage 1: scale to millivolts and saturate
  logic            s1_v_r;
  logic [MV_W-1:0] s1_mv_r, s1_mv_nxt;
  logic [GP-1:0]   gprod, mvw;

  always_comb begin
    gprod     = GP'(gain_r) * GP'(in_tdata[ADC_BITS-1:0]);
    mvw       = gprod >> 10;
    s1_mv_nxt = (mvw > GP'(MV_MAX)) ? MV_W'(MV_MAX) : mvw[MV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
    end
    if (adv) begin
      s1_mv_r <= s1_mv_nxt;
    end
  end

  // Stage 2: classify and normalize both log operands
  function automatic logic [K_W-1:0] msb_idx(input logic [MV_W-1:0] x);
    logic [K_W-1:0] k;
    k = '0;
    for (int i = 0; i < MV_W; i++) begin
      if (x[i]) k = K_W'(i);
    end
    return k;
  endfunction

  logic                s2_v_r;
  ntcb_tag_t           s2_tag_r, s2_tag_nxt;
  logic [MANT_W-1:0]   s2_ma_r, s2_mb_r;
  logic [K_W-1:0]      s2_ka_r, s2_kb_r, ka_nxt, kb_nxt;
  logic [MV_W-1:0]     xb;

  always_comb begin
    xb                = ref_r - s1_mv_r;
    s2_tag_nxt.mv     = s1_mv_r;
    s2_tag_nxt.sat    = 1'b0;
    priority if (s1_mv_r == '0) begin
      s2_tag_nxt.status = ST_ZERO;
    end else if (s1_mv_r >= ref_r) begin
      s2_tag_nxt.status = ST_HIGH;
    end else begin
      s2_tag_nxt.status = ST_OK;
    end
    ka_nxt = msb_idx(s1_mv_r);
    kb_nxt = msb_idx(xb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
    if (adv) begin
      s2_tag_r <= s2_tag_nxt;
      s2_ka_r  <= ka_nxt;
      s2_kb_r  <= kb_nxt;
      s2_ma_r  <= MANT_W'(s1_mv_r) << (MANT_W - 1 - int'(ka_nxt));
      s2_mb_r  <= MANT_W'(xb) << (MANT_W - 1 - int'(kb_nxt));
    end
  end

  // Log2 chain: one squaring cell per fraction bit
  logic              lc_v   [F+1];
  ntcb_tag_t         lc_tag [F+1];
  logic [MANT_W-1:0] lc_ma  [F+1];
  logic [MANT_W-1:0] lc_mb  [F+1];
  logic [F-1:0]      lc_fa  [F+1];
  logic [F-1:0]      lc_fb  [F+1];
  logic [K_W-1:0]    lc_ka  [F+1];
  logic [K_W-1:0]    lc_kb  [F+1];

  assign lc_v[0]   = s2_v_r;
  assign lc_tag[0] = s2_tag_r;
  assign lc_ma[0]  = s2_ma_r;
  assign lc_mb[0]  = s2_mb_r;
  assign lc_fa[0]  = '0;
  assign lc_fb[0]  = '0;
  assign lc_ka[0]  = s2_ka_r;
  assign lc_kb[0]  = s2_kb_r;

  for (genvar g = 0; g < F; g++) begin : g_log
    ntcb_log_cell #(.FRAC_BITS(F)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .v_in    (lc_v[g]),
      .tag_in  (lc_tag[g]),
      .ma_in   (lc_ma[g]),
      .mb_in   (lc_mb[g]),
      .fa_in   (lc_fa[g]),
      .fb_in   (lc_fb[g]),
      .ka_in   (lc_ka[g]),
      .kb_in   (lc_kb[g]),
      .v_out   (lc_v[g+1]),
      .tag_out (lc_tag[g+1]),
      .ma_out  (lc_ma[g+1]),
      .mb_out  (lc_mb[g+1]),
      .fa_out  (lc_fa[g+1]),
      .fb_out  (lc_fb[g+1]),
      .ka_out  (lc_ka[g+1]),
      .kb_out  (lc_kb[g+1])
    );
  end

  // Stage A: log difference magnitude times ln 2
  logic           sa_v_r, sa_neg_r, sa_neg_nxt;
  ntcb_tag_t      sa_tag_r;
  logic [LW+29:0] sa_prod_r;
  logic [LW-1:0]  l_num, l_den, dmag;

  always_comb begin
    l_num      = {lc_ka[F], lc_fa[F]};
    l_den      = {lc_kb[F], lc_fb[F]};
    sa_neg_nxt = (l_num < l_den);
    dmag       = sa_neg_nxt ? (l_den - l_num) : (l_num - l_den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
    end else if (adv) begin
      sa_v_r <= lc_v[F];
    end
    if (adv) begin
      sa_tag_r  <= lc_tag[F];
      sa_neg_r  <= sa_neg_nxt;
      sa_prod_r <= (LW+30)'(dmag) * (LW+30)'(LN2_Q30);
    end
  end

  // Stage B: round ln r, form To*ln r and the numerator base
  logic                  sb_v_r;
  ntcb_tag_t             sb_tag_r;
  logic signed [TLW-1:0] sb_tl_r, tl_nxt;
  logic [36:0]           sb_numb_r;
  logic [LW+30:0]        rsum;
  logic [LW:0]           lnm;
  logic signed [LW+1:0]  lnq;

  always_comb begin
    rsum   = {1'b0, sa_prod_r} + (LW+31)'(32'd1 << 29);
    lnm    = rsum[LW+30:30];
    lnq    = sa_neg_r ? -$signed({1'b0, lnm}) : $signed({1'b0, lnm});
    tl_nxt = $signed({{(TLW-16){1'b0}}, nom_r}) * $signed({{(TLW-LW-2){lnq[LW+1]}}, lnq});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= 1'b0;
    end else if (adv) begin
      sb_v_r <= sa_v_r;
    end
    if (adv) begin
      sb_tag_r  <= sa_tag_r;
      sb_tl_r   <= tl_nxt;
      sb_numb_r <= 37'(nom_r) * 37'(b100_r);
    end
  end

  // Stage C: denominator and scaled numerator
  logic                 sc_v_r;
  ntcb_tag_t            sc_tag_r;
  logic signed [DW-1:0] sc_den_r;
  logic [NUMW-1:0]      sc_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
    end else if (adv) begin
      sc_v_r <= sb_v_r;
    end
    if (adv) begin
      sc_tag_r <= sb_tag_r;
      sc_den_r <= $signed({{(DW-TLW){sb_tl_r[TLW-1]}}, sb_tl_r})
                + $signed({{(DW-21-F){1'b0}}, b100_r, {F{1'b0}}});
      sc_num_r <= {sb_numb_r, {F{1'b0}}};
    end
  end

  // Stage D: rounding offset and overflow check ahead of the divider
  logic             sd_v_r;
  ntcb_tag_t        sd_tag_r, sd_tag_nxt;
  logic [REM_W-1:0] sd_rem_r, nsum;
  logic [UDW-1:0]   sd_den_r, uden;
  logic             dpos;

  always_comb begin
    dpos           = !sc_den_r[DW-1] && (sc_den_r != '0);
    uden           = sc_den_r[UDW-1:0];
    nsum           = REM_W'(NW'(sc_num_r) + NW'(uden >> 1));
    sd_tag_nxt     = sc_tag_r;
    sd_tag_nxt.sat = !dpos || (nsum >= (REM_W'(uden) << QB));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_v_r <= 1'b0;
    end else if (adv) begin
      sd_v_r <= sc_v_r;
    end
    if (adv) begin
      sd_tag_r <= sd_tag_nxt;
      sd_rem_r <= nsum;
      sd_den_r <= uden;
    end
  end

  // Divider chain: one quotient bit per cell, most significant first
  logic             dc_v   [QB+1];
  ntcb_tag_t        dc_tag [QB+1];
  logic [REM_W-1:0] dc_rem [QB+1];
  logic [UDW-1:0]   dc_den [QB+1];
  logic [QB-1:0]    dc_q   [QB+1];

  assign dc_v[0]   = sd_v_r;
  assign dc_tag[0] = sd_tag_r;
  assign dc_rem[0] = sd_rem_r;
  assign dc_den[0] = sd_den_r;
  assign dc_q[0]   = '0;

  for (genvar d = 0; d < QB; d++) begin : g_div
    ntcb_div_cell #(.REM_W(REM_W), .DEN_W(UDW), .SHIFT(QB - 1 - d)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .v_in    (dc_v[d]),
      .tag_in  (dc_tag[d]),
      .rem_in  (dc_rem[d]),
      .den_in  (dc_den[d]),
      .q_in    (dc_q[d]),
      .v_out   (dc_v[d+1]),
      .tag_out (dc_tag[d+1]),
      .rem_out (dc_rem[d+1]),
      .den_out (dc_den[d+1]),
      .q_out   (dc_q[d+1])
    );
  end

  // Stage E: convert to Celsius, clamp, pack the result beat
  ntcb_tag_t          ft;
  logic [QB-1:0]      tk;
  logic signed [QB:0] tc;
  logic [TEMP_W-1:0]  temp_nxt;

  always_comb begin
    ft = dc_tag[QB];
    tk = dc_q[QB];
    tc = $signed({1'b0, tk}) - $signed((QB+1)'(ZERO_C_CENTIK));
    priority if (ft.status != ST_OK) begin
      temp_nxt = '0;
    end else if (ft.sat || (tk > QB'(TEMP_MAX + ZERO_C_CENTIK))) begin
      temp_nxt = TEMP_W'(TEMP_MAX);
    end else if (tc < $signed((QB+1)'(TEMP_MIN))) begin
      temp_nxt = TEMP_W'(TEMP_MIN);
    end else begin
      temp_nxt = tc[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dc_v[QB];
    end
    if (adv) begin
      out_data_r <= {ft.status, temp_nxt, ft.mv};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // Checks on pipeline control and result encoding
  `NTCB_ASSERT_IMPLY(a_stall_holds_input, out_tvalid && !out_tready, !in_tready, "input taken while result stalled")
  `NTCB_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, s1_v_r, "accepted beat lost at stage one")
  `NTCB_ASSERT_IMPLY(a_fault_zero_temp, out_tvalid && (out_tdata[31:30] != ST_OK), out_tdata[29:12] == '0, "fault result with nonzero temperature")
  `NTCB_ASSERT_IMPLY(a_temp_range, out_tvalid, ($signed(out_tdata[29:12]) <= TEMP_MAX) && ($signed(out_tdata[29:12]) >= TEMP_MIN), "temperature outside clamp range")

endmodule
